// File: hdl/lfc_pkg.sv
// ----------------------------------------------------------------------------
// lfc_pkg
// Shared types, constants and helpers of the line FIR convolver.
// ----------------------------------------------------------------------------
package lfc_pkg;

    // Fixed field widths
    localparam int COEF_BITS       = 16;
    localparam int TAP_OFFSET_BITS = 4;
    localparam int NUM_COEF        = 7;
    localparam int MAX_LEAD        = 6;
    localparam int LEAD_BITS       = 3;

    // Configuration port
    localparam int APB_DATA_BITS = 32;
    localparam int APB_ADDR_BITS = 5;
    localparam int REG_IDX_BITS  = 3;

    // Register map, by index
    localparam logic [REG_IDX_BITS-1:0] REG_TAP_OFFSET = 3'd0;
    localparam logic [REG_IDX_BITS-1:0] REG_COEF_0     = 3'd1;

    // Reset values
    localparam logic signed [TAP_OFFSET_BITS-1:0] TAP_OFFSET_RESET = -4'sd3;
    localparam int                                COEF_UNITY_TAP   = 3;
    localparam logic signed [COEF_BITS-1:0]       COEF_UNITY       = 16'sd16384;

    typedef enum logic {
        SEQ_IDLE,
        SEQ_FLUSH
    } t_seq_state;

    // Control that travels with one request through the pipeline
    typedef struct packed {
        logic valid;
        logic last;
    } t_emit_ctl;

    // Lead of the window over the output, from the tap offset, clamped to 0..MAX_LEAD
    function automatic logic [LEAD_BITS-1:0] lead_of(
        input logic signed [TAP_OFFSET_BITS-1:0] tap
    );
        logic [LEAD_BITS-1:0] lead;
        if (tap > 0) begin
            lead = '0;
        end else if (tap < -MAX_LEAD) begin
            lead = LEAD_BITS'(MAX_LEAD);
        end else begin
            lead = LEAD_BITS'(-tap);
        end
        return lead;
    endfunction

endpackage

// File: hdl/lfc_window.sv
// ----------------------------------------------------------------------------
// lfc_window
// Sample window, lead counter and line-end flush sequencer.
// ----------------------------------------------------------------------------
module lfc_window #(
    parameter int NUM_TAPS   = 7,
    parameter int PIXEL_BITS = 16
) (
    input  logic                                        i_clk,
    input  logic                                        i_rst_n,
    input  logic signed [lfc_pkg::TAP_OFFSET_BITS-1:0]  i_tap_offset,
    input  logic                                        i_in_valid,
    output logic                                        o_in_stall,
    input  logic signed [PIXEL_BITS-1:0]                i_pixel_in,
    input  logic                                        i_line_end,
    input  logic                                        i_ready,
    output lfc_pkg::t_emit_ctl                          o_emit,
    output logic signed [PIXEL_BITS-1:0]                o_win [NUM_TAPS]
);

    lfc_pkg::t_seq_state r_state, n_state;

    logic signed [PIXEL_BITS-1:0] r_win [NUM_TAPS];
    logic signed [PIXEL_BITS-1:0] n_win [NUM_TAPS];
    logic [lfc_pkg::LEAD_BITS-1:0] r_lead_cnt, n_lead_cnt;
    logic [lfc_pkg::LEAD_BITS-1:0] r_left, n_left;

    logic signed [PIXEL_BITS-1:0] win_push [NUM_TAPS];
    logic signed [PIXEL_BITS-1:0] win_fz   [NUM_TAPS];
    logic signed [PIXEL_BITS-1:0] win_sil  [NUM_TAPS];

    logic [lfc_pkg::LEAD_BITS-1:0] lead, lc_new, owed, silent;
    logic lc_full, accept;

    assign lead    = lfc_pkg::lead_of(i_tap_offset);
    assign lc_full = (r_lead_cnt >= lead);
    assign lc_new  = lc_full ? r_lead_cnt : r_lead_cnt + 1'b1;
    assign owed    = (lc_new < lead) ? lc_new : lead;
    assign silent  = lead - owed;

    assign o_in_stall = (r_state == lfc_pkg::SEQ_FLUSH) || !i_ready;
    assign accept     = i_in_valid && !o_in_stall;

    // Window shapes: push the new pixel, push a zero, and push the silent zeros
    always_comb begin
        win_push[0] = i_pixel_in;
        win_fz[0]   = '0;
        for (int k = 1; k < NUM_TAPS; k++) begin
            win_push[k] = r_win[k-1];
            win_fz[k]   = r_win[k-1];
        end
        for (int k = 0; k < NUM_TAPS; k++) begin
            win_sil[k] = '0;
            for (int s = 0; s <= lfc_pkg::MAX_LEAD; s++) begin
                if ((int'(silent) == s) && (k >= s)) begin
                    win_sil[k] = win_push[k-s];
                end
            end
        end
    end

    // Next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            lfc_pkg::SEQ_IDLE: begin
                if (accept && i_line_end && (owed != '0)) begin
                    n_state = lfc_pkg::SEQ_FLUSH;
                end
            end
            lfc_pkg::SEQ_FLUSH: begin
                if (i_ready && (r_left == lfc_pkg::LEAD_BITS'(1))) begin
                    n_state = lfc_pkg::SEQ_IDLE;
                end
            end
        endcase
    end

    // Outputs
    always_comb begin
        o_emit = '0;
        o_win  = win_push;
        unique case (r_state)
            lfc_pkg::SEQ_IDLE: begin
                o_emit.valid = accept && lc_full;
                o_emit.last  = i_line_end && (owed == '0);
            end
            lfc_pkg::SEQ_FLUSH: begin
                o_win        = win_fz;
                o_emit.valid = i_ready;
                o_emit.last  = (r_left == lfc_pkg::LEAD_BITS'(1));
            end
        endcase
    end

    // Window and counters
    always_comb begin
        n_win      = r_win;
        n_lead_cnt = r_lead_cnt;
        n_left     = r_left;
        unique case (r_state)
            lfc_pkg::SEQ_IDLE: begin
                if (accept) begin
                    if (!i_line_end) begin
                        n_win      = win_push;
                        n_lead_cnt = lc_new;
                    end else if (owed == '0) begin
                        for (int k = 0; k < NUM_TAPS; k++) n_win[k] = '0;
                        n_lead_cnt = '0;
                    end else begin
                        n_win  = win_sil;
                        n_left = owed;
                    end
                end
            end
            lfc_pkg::SEQ_FLUSH: begin
                if (i_ready) begin
                    n_left = r_left - 1'b1;
                    if (r_left == lfc_pkg::LEAD_BITS'(1)) begin
                        for (int k = 0; k < NUM_TAPS; k++) n_win[k] = '0;
                        n_lead_cnt = '0;
                    end else begin
                        n_win = win_fz;
                    end
                end
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= lfc_pkg::SEQ_IDLE;
            r_lead_cnt <= '0;
            r_left     <= '0;
            for (int k = 0; k < NUM_TAPS; k++) r_win[k] <= '0;
        end else begin
            r_state    <= n_state;
            r_lead_cnt <= n_lead_cnt;
            r_left     <= n_left;
            r_win      <= n_win;
        end
    end

endmodule

// File: hdl/lfc_mac.sv
// ----------------------------------------------------------------------------
// lfc_mac
// Multiply, add tree, rounding and saturation, with output register.
// ----------------------------------------------------------------------------
module lfc_mac #(
    parameter int NUM_TAPS   = 7,
    parameter int PIXEL_BITS = 16,
    parameter int FRAC_BITS  = 14
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  lfc_pkg::t_emit_ctl                    i_emit,
    input  logic signed [PIXEL_BITS-1:0]          i_win  [NUM_TAPS],
    input  logic signed [lfc_pkg::COEF_BITS-1:0]  i_coef [NUM_TAPS],
    output logic                                  o_ready,
    output logic                                  o_out_valid,
    input  logic                                  i_out_stall,
    output logic signed [PIXEL_BITS-1:0]          o_pixel_out,
    output logic                                  o_out_line_end
);

    localparam int PROD_W = PIXEL_BITS + lfc_pkg::COEF_BITS;
    localparam int PAIR_W = PROD_W + 1;
    localparam int SUM_W  = PROD_W + 3;
    localparam int NPAIR  = (NUM_TAPS + 1) / 2;

    localparam logic signed [SUM_W-1:0] ROUND_HALF = SUM_W'(64'sd1 <<< (FRAC_BITS - 1));
    localparam logic signed [SUM_W-1:0] SAT_HI     =
        SUM_W'((64'sd1 <<< (PIXEL_BITS - 1)) - 64'sd1);
    localparam logic signed [SUM_W-1:0] SAT_LO     = -SAT_HI - SUM_W'(1);

    lfc_pkg::t_emit_ctl r_c1, r_c2, r_c3, r_cout;

    logic signed [PROD_W-1:0] r_prod [NUM_TAPS];
    logic signed [PAIR_W-1:0] r_pair [NPAIR];
    logic signed [SUM_W-1:0]  r_sum;
    logic signed [PIXEL_BITS-1:0] r_pix;

    logic signed [PAIR_W-1:0] n_pair [NPAIR];
    logic signed [SUM_W-1:0]  n_sum;
    logic signed [SUM_W-1:0]  shifted;
    logic signed [PIXEL_BITS-1:0] n_pix;

    logic rdy_out, rdy3, rdy2, rdy1;

    assign rdy_out = !r_cout.valid || !i_out_stall;
    assign rdy3    = !r_c3.valid || rdy_out;
    assign rdy2    = !r_c2.valid || rdy3;
    assign rdy1    = !r_c1.valid || rdy2;
    assign o_ready = rdy1;

    always_comb begin
        for (int p = 0; p < NPAIR; p++) begin
            n_pair[p] = PAIR_W'(r_prod[2*p]);
            if (2*p + 1 < NUM_TAPS) begin
                n_pair[p] = n_pair[p] + PAIR_W'(r_prod[2*p+1]);
            end
        end
    end

    always_comb begin
        n_sum = ROUND_HALF;
        for (int p = 0; p < NPAIR; p++) begin
            n_sum = n_sum + SUM_W'(r_pair[p]);
        end
    end

    // Floor shift, then clamp to the pixel range
    always_comb begin
        shifted = r_sum >>> FRAC_BITS;
        if (shifted > SAT_HI) begin
            n_pix = SAT_HI[PIXEL_BITS-1:0];
        end else if (shifted < SAT_LO) begin
            n_pix = SAT_LO[PIXEL_BITS-1:0];
        end else begin
            n_pix = shifted[PIXEL_BITS-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_c1   <= '0;
            r_c2   <= '0;
            r_c3   <= '0;
            r_cout <= '0;
        end else begin
            if (rdy1)    r_c1   <= i_emit;
            if (rdy2)    r_c2   <= r_c1;
            if (rdy3)    r_c3   <= r_c2;
            if (rdy_out) r_cout <= r_c3;
        end
    end

    always_ff @(posedge i_clk) begin
        if (rdy1 && i_emit.valid) begin
            for (int k = 0; k < NUM_TAPS; k++) begin
                r_prod[k] <= PROD_W'(i_win[k]) * PROD_W'(i_coef[k]);
            end
        end
        if (rdy2 && r_c1.valid) r_pair <= n_pair;
        if (rdy3 && r_c2.valid) r_sum  <= n_sum;
        if (rdy_out && r_c3.valid) r_pix <= n_pix;
    end

    assign o_out_valid    = r_cout.valid;
    assign o_out_line_end = r_cout.last;
    assign o_pixel_out    = r_pix;

endmodule

// File: hdl/line_fir_convolver.sv
// ----------------------------------------------------------------------------
// line_fir_convolver
// Streaming zero-padded 1-D convolution of one image line, up to seven taps.
// ----------------------------------------------------------------------------
// Takes one pixel per clock unless stalled and returns one convolved pixel per input
// pixel; the request that completes its window passes the product, pair-sum, sum and
// output registers. The first d outputs of a line (d = minus the tap offset, clamped
// to 0..6) wait until enough of the window has arrived; when the last pixel of a line
// is taken, the outputs still owed are produced by the flush sequencer, which shifts
// one zero into the window per cycle while the pipeline is ready and holds the input
// stalled until the flush is done. Each output needs one slot in the four-stage
// multiply / add / round pipeline, so a stalled output side backs up into the input
// only once all stages are full. Coefficients are Q2.14; the sum is rounded half up,
// shifted right by FRAC_BITS and clamped to PIXEL_BITS. Configuration is written
// through the APB port, one register per word, and must only change while no line is
// in flight.
module line_fir_convolver #(
    parameter int NUM_TAPS   = 7,
    parameter int PIXEL_BITS = 16,
    parameter int FRAC_BITS  = 14
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,

    // Configuration port
    input  logic                                  psel,
    input  logic                                  penable,
    input  logic                                  pwrite,
    input  logic [lfc_pkg::APB_ADDR_BITS-1:0]     paddr,
    input  logic [lfc_pkg::APB_DATA_BITS-1:0]     pwdata,
    output logic [lfc_pkg::APB_DATA_BITS-1:0]     prdata,
    output logic                                  pready,

    // Pixel input
    input  logic                                  i_in_valid,
    output logic                                  o_in_stall,
    input  logic signed [PIXEL_BITS-1:0]          i_pixel_in,
    input  logic                                  i_line_end,

    // Pixel output
    output logic                                  o_out_valid,
    input  logic                                  i_out_stall,
    output logic signed [PIXEL_BITS-1:0]          o_pixel_out,
    output logic                                  o_out_line_end
);

    logic signed [lfc_pkg::TAP_OFFSET_BITS-1:0] r_tap_offset;
    logic signed [lfc_pkg::COEF_BITS-1:0]       r_coef [lfc_pkg::NUM_COEF];

    logic [lfc_pkg::REG_IDX_BITS-1:0] reg_idx;
    logic [lfc_pkg::REG_IDX_BITS-1:0] coef_idx;
    logic                             wr_en;

    lfc_pkg::t_emit_ctl           emit;
    logic signed [PIXEL_BITS-1:0] win  [NUM_TAPS];
    logic signed [lfc_pkg::COEF_BITS-1:0] coef [NUM_TAPS];
    logic                         mac_ready;

    // ---------------------------------------------------------------- config
    // Word addressed; the low two address bits carry no meaning.
    assign reg_idx  = paddr[lfc_pkg::APB_ADDR_BITS-1:2];
    assign coef_idx = reg_idx - lfc_pkg::REG_COEF_0;
    assign wr_en    = psel && penable && pwrite;
    assign pready   = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tap_offset <= lfc_pkg::TAP_OFFSET_RESET;
            for (int k = 0; k < lfc_pkg::NUM_COEF; k++) begin
                r_coef[k] <= (k == lfc_pkg::COEF_UNITY_TAP) ? lfc_pkg::COEF_UNITY : '0;
            end
        end else if (wr_en) begin
            if (reg_idx == lfc_pkg::REG_TAP_OFFSET) begin
                r_tap_offset <= pwdata[lfc_pkg::TAP_OFFSET_BITS-1:0];
            end else begin
                r_coef[coef_idx] <= pwdata[lfc_pkg::COEF_BITS-1:0];
            end
        end
    end

    // Read back sign-extended to the bus width
    always_comb begin
        if (reg_idx == lfc_pkg::REG_TAP_OFFSET) begin
            prdata = lfc_pkg::APB_DATA_BITS'(r_tap_offset);
        end else begin
            prdata = lfc_pkg::APB_DATA_BITS'(r_coef[coef_idx]);
        end
    end

    // Coefficient k weights the sample k places behind the newest one
    always_comb begin
        for (int k = 0; k < NUM_TAPS; k++) begin
            coef[k] = r_coef[k];
        end
    end

    // ---------------------------------------------------------------- window
    // Shift in the pixel, decide whether an output is due, and run the
    // line-end flush. Only issue a request when the pipeline can take it.
    lfc_window #(
        .NUM_TAPS   (NUM_TAPS),
        .PIXEL_BITS (PIXEL_BITS)
    ) u_window (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_tap_offset (r_tap_offset),
        .i_in_valid   (i_in_valid),
        .o_in_stall   (o_in_stall),
        .i_pixel_in   (i_pixel_in),
        .i_line_end   (i_line_end),
        .i_ready      (mac_ready),
        .o_emit       (emit),
        .o_win        (win)
    );

    // ---------------------------------------------------------------- datapath
    // Products, pair sums, final sum with rounding, clamp into the output
    // register; each stage advances as soon as the one after it has room.
    lfc_mac #(
        .NUM_TAPS   (NUM_TAPS),
        .PIXEL_BITS (PIXEL_BITS),
        .FRAC_BITS  (FRAC_BITS)
    ) u_mac (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_emit         (emit),
        .i_win          (win),
        .i_coef         (coef),
        .o_ready        (mac_ready),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .o_pixel_out    (o_pixel_out),
        .o_out_line_end (o_out_line_end)
    );

endmodule

// File: hdl/lfc_checker.sv
// ----------------------------------------------------------------------------
// lfc_checker
// Port-level checks of the line FIR convolver, bound to the top level.
// ----------------------------------------------------------------------------
module lfc_checker #(
    parameter int PIXEL_BITS = 16
) (
    input logic                              i_clk,
    input logic                              i_rst_n,
    input logic                              psel,
    input logic                              penable,
    input logic                              pwrite,
    input logic [lfc_pkg::APB_ADDR_BITS-1:0] paddr,
    input logic [lfc_pkg::APB_DATA_BITS-1:0] pwdata,
    input logic [lfc_pkg::APB_DATA_BITS-1:0] prdata,
    input logic                              pready,
    input logic                              o_out_valid,
    input logic                              i_out_stall,
    input logic signed [PIXEL_BITS-1:0]      o_pixel_out
);

    logic wr_coef;
    assign wr_coef = psel && penable && pwrite && pready &&
                     (paddr[lfc_pkg::APB_ADDR_BITS-1:2] != lfc_pkg::REG_TAP_OFFSET);

    // Reset drops any pending result
    a_reset_clears: assert property (@(posedge i_clk) !i_rst_n |=> !o_out_valid)
        else $error("output valid after reset");

    // A stalled result stays offered
    a_valid_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_pixel_out))
        else $error("stalled result dropped or changed");

    // A coefficient written reads back at once, sign-extended
    a_coef_readback: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(i_rst_n) && $past(wr_coef) && psel && !pwrite && paddr == $past(paddr)
        |-> prdata[lfc_pkg::COEF_BITS-1:0] == $past(pwdata[lfc_pkg::COEF_BITS-1:0]) &&
            (prdata[lfc_pkg::APB_DATA_BITS-1:lfc_pkg::COEF_BITS-1] == '0 ||
             prdata[lfc_pkg::APB_DATA_BITS-1:lfc_pkg::COEF_BITS-1] == '1))
        else $error("coefficient read-back mismatch");

    // Tap offset reads back sign-extended
    a_tap_sext: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        psel && !pwrite && paddr[lfc_pkg::APB_ADDR_BITS-1:2] == lfc_pkg::REG_TAP_OFFSET
        |-> prdata[lfc_pkg::APB_DATA_BITS-1:lfc_pkg::TAP_OFFSET_BITS-1] == '0 ||
            prdata[lfc_pkg::APB_DATA_BITS-1:lfc_pkg::TAP_OFFSET_BITS-1] == '1)
        else $error("tap offset read-back not sign-extended");

endmodule

bind line_fir_convolver lfc_checker #(
    .PIXEL_BITS (PIXEL_BITS)
) u_lfc_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready),
    .o_out_valid (o_out_valid),
    .i_out_stall (i_out_stall),
    .o_pixel_out (o_pixel_out)
);
